// ----- design/tzcof_pkg.sv -----
// shared types and constants of the tzif current offset finder
package tzcof_pkg;

  localparam int MAGIC_LEN  = 4;
  localparam int SKIP_LEN   = 16;
  localparam int COUNTS_LEN = 24;
  localparam int HEADER_LEN = MAGIC_LEN + SKIP_LEN + COUNTS_LEN;
  localparam int TTINFO_LEN = 6;

  localparam logic [7:0] MAGIC [MAGIC_LEN] = '{8'h54, 8'h5a, 8'h69, 8'h66};

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_UTC       = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  localparam int TDATA_W = 96;
  localparam int TUSER_W = 3;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] zone_offset;
    logic [7:0]         dst_flag;
    logic [7:0]         abbr_offset;
    logic [7:0]         chosen_type;
    logic               has_next;
    logic signed [31:0] next_change;
  } tzcof_result_t;

endpackage

// ----- design/tzcof_parser.sv -----
// byte-level tzif parser: header check, transition search, type capture
module tzcof_parser
  import tzcof_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          file_byte,
  input  logic                last_byte,
  input  logic signed [63:0]  current_time,
  output tzcof_result_t       result
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TIMES,
    PH_INDEX,
    PH_TYPES,
    PH_TAIL,
    PH_BAD
  } phase_t;

  localparam logic [31:0] POS_SKIP_END   = 32'(MAGIC_LEN + SKIP_LEN);
  localparam logic [31:0] POS_TCOUNT_END = 32'(MAGIC_LEN + SKIP_LEN + 15);
  localparam logic [31:0] POS_YCOUNT_END = 32'(MAGIC_LEN + SKIP_LEN + 19);
  localparam logic [31:0] POS_HDR_END    = 32'(HEADER_LEN);
  localparam logic [2:0]  ITEM_LAST      = 3'(TTINFO_LEN - 1);

  phase_t      phase, phase_next;
  logic [31:0] section_position, section_position_next;
  logic [2:0]  item_byte, item_byte_next;
  logic [31:0] word_gather, word_gather_next;
  logic [31:0] transition_total, transition_total_next;
  logic [31:0] type_total, type_total_next;
  logic [31:0] passed_total, passed_total_next;
  logic        search_stopped, search_stopped_next;
  logic [31:0] next_time, next_time_next;
  logic        next_seen, next_seen_next;
  logic [7:0]  type_choice, type_choice_next;
  logic [31:0] offset_hold, offset_hold_next;
  logic [7:0]  dst_hold, dst_hold_next;
  logic [7:0]  abbr_hold, abbr_hold_next;

  logic [31:0]        word_shift;
  logic [31:0]        pos_inc;
  logic signed [63:0] time_ext;

  assign word_shift = {word_gather[23:0], file_byte};
  assign pos_inc    = section_position + 32'd1;
  assign time_ext   = {{32{word_shift[31]}}, word_shift};

  always_comb begin
    phase_next            = phase;
    section_position_next = section_position;
    item_byte_next        = item_byte;
    word_gather_next      = word_gather;
    transition_total_next = transition_total;
    type_total_next       = type_total;
    passed_total_next     = passed_total;
    search_stopped_next   = search_stopped;
    next_time_next        = next_time;
    next_seen_next        = next_seen;
    type_choice_next      = type_choice;
    offset_hold_next      = offset_hold;
    dst_hold_next         = dst_hold;
    abbr_hold_next        = abbr_hold;

    case (phase)
      PH_HEADER: begin
        if (section_position < 32'(MAGIC_LEN) &&
            file_byte != MAGIC[section_position[1:0]]) begin
          phase_next = PH_BAD;
        end else begin
          if (section_position >= POS_SKIP_END) begin
            word_gather_next = word_shift;
            if (section_position == POS_TCOUNT_END) transition_total_next = word_shift;
            if (section_position == POS_YCOUNT_END) type_total_next = word_shift;
          end
          section_position_next = pos_inc;
          if (pos_inc == POS_HDR_END) begin
            section_position_next = '0;
            item_byte_next        = '0;
            if (transition_total_next != '0) phase_next = PH_TIMES;
            else if (type_total_next != '0) phase_next = PH_TYPES;
            else phase_next = PH_TAIL;
          end
        end
      end
      PH_TIMES: begin
        word_gather_next = word_shift;
        item_byte_next   = item_byte + 3'd1;
        if (item_byte == 3'd3) begin
          item_byte_next = '0;
          if (!search_stopped) begin
            if (time_ext <= current_time) begin
              passed_total_next = passed_total + 32'd1;
            end else begin
              search_stopped_next = 1'b1;
              next_seen_next      = 1'b1;
              next_time_next      = word_shift;
            end
          end
          section_position_next = pos_inc;
          if (pos_inc == transition_total) begin
            section_position_next = '0;
            phase_next            = PH_INDEX;
          end
        end
      end
      PH_INDEX: begin
        if (passed_total != '0 && section_position == passed_total - 32'd1)
          type_choice_next = file_byte;
        section_position_next = pos_inc;
        if (pos_inc == transition_total) begin
          section_position_next = '0;
          item_byte_next        = '0;
          phase_next            = (type_total != '0) ? PH_TYPES : PH_TAIL;
        end
      end
      PH_TYPES: begin
        if (section_position == {24'd0, type_choice}) begin
          if (item_byte < 3'd4) offset_hold_next = {offset_hold[23:0], file_byte};
          else if (item_byte == 3'd4) dst_hold_next = file_byte;
          else abbr_hold_next = file_byte;
        end
        item_byte_next = item_byte + 3'd1;
        if (item_byte == ITEM_LAST) begin
          item_byte_next        = '0;
          section_position_next = pos_inc;
          if (pos_inc == type_total) begin
            section_position_next = '0;
            phase_next            = PH_TAIL;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result as seen after the current byte
  always_comb begin
    result = '0;
    if (phase_next == PH_BAD) begin
      result.status = ST_BAD_MAGIC;
    end else if (phase_next != PH_TAIL) begin
      result.status = ST_TRUNC;
    end else if (transition_total_next == '0 && type_total_next == '0) begin
      result.status = ST_UTC;
    end else begin
      if ({24'd0, type_choice_next} < type_total_next) begin
        result.status      = ST_OK;
        result.zone_offset = offset_hold_next;
        result.dst_flag    = dst_hold_next;
        result.abbr_offset = abbr_hold_next;
      end else begin
        result.status = ST_RANGE;
      end
      result.chosen_type = type_choice_next;
      result.has_next    = next_seen_next;
      result.next_change = next_seen_next ? next_time_next : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      phase            <= PH_HEADER;
      section_position <= '0;
      item_byte        <= '0;
      word_gather      <= '0;
      transition_total <= '0;
      type_total       <= '0;
      passed_total     <= '0;
      search_stopped   <= 1'b0;
      next_time        <= '0;
      next_seen        <= 1'b0;
      type_choice      <= '0;
      offset_hold      <= '0;
      dst_hold         <= '0;
      abbr_hold        <= '0;
    end else if (take) begin
      phase            <= phase_next;
      section_position <= section_position_next;
      item_byte        <= item_byte_next;
      word_gather      <= word_gather_next;
      transition_total <= transition_total_next;
      type_total       <= type_total_next;
      passed_total     <= passed_total_next;
      search_stopped   <= search_stopped_next;
      next_time        <= next_time_next;
      next_seen        <= next_seen_next;
      type_choice      <= type_choice_next;
      offset_hold      <= offset_hold_next;
      dst_hold         <= dst_hold_next;
      abbr_hold        <= abbr_hold_next;
    end
  end

endmodule

// ----- design/tzif_current_offset_finder_top.sv -----
// top level of the tzif current offset finder
//
// usage:
// - the s_ channel takes the bytes of a tzif (v1) file, one per request,
//   with s_tlast high on the final byte of the file
// - the m_ channel gives one result request per file, status in m_tuser
// - cfg_ writes current_time (64-bit signed); cfg_ready is always high,
//   write only while no file is in flight
// throughput: one byte per cycle while s_tready is high, set by the single
//   parser pass from the parse state registers to the result register
// output: the result is registered in the output buffer before m_ shows it
// stall: results go to a two-entry output buffer (result register plus
//   skid); s_tready drops only while both entries are full
// reset: rst (synchronous) clears the parse state, empties the output
//   buffer and sets current_time to zero
// after each result the parser is back in its header state for a new file
module tzif_current_offset_finder_top
  import tzcof_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input bytes
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,    // [7:0] file_byte
  input  logic               s_tlast,    // last_byte
  // results
  output logic               m_tvalid,
  input  logic               m_tready,
  // [31:0] zone_offset, [39:32] dst_flag, [47:40] abbr_offset,
  // [55:48] chosen_type, [56] has_next, [88:57] next_change, [95:89] zero
  output logic [TDATA_W-1:0] m_tdata,
  output logic [TUSER_W-1:0] m_tuser,    // [2:0] status
  // current time register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [63:0]        cfg_data
);

  logic signed [63:0] current_time;
  logic               take;
  logic               push;
  logic               pop;
  tzcof_result_t      new_result;

  // output buffer: head drives m_, skid catches a result while head stalls
  tzcof_result_t      head;
  tzcof_result_t      skid;
  logic               head_valid;
  logic               skid_valid;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign take      = s_tvalid && s_tready;
  assign push      = take && s_tlast;
  assign pop       = head_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
    end else if (cfg_valid && cfg_ready) begin
      current_time <= cfg_data;
    end
  end

  tzcof_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .file_byte    (s_tdata),
    .last_byte    (s_tlast),
    .current_time (current_time),
    .result       (new_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        // skid moves up, a new result, if any, takes its place
        head       <= skid;
        skid       <= new_result;
        skid_valid <= push;
      end else begin
        head       <= new_result;
        head_valid <= push;
      end
    end else if (push) begin
      if (!head_valid) begin
        head       <= new_result;
        head_valid <= 1'b1;
      end else begin
        skid       <= new_result;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_tvalid = head_valid;
  assign m_tuser  = head.status;
  assign m_tdata  = {7'd0, head.next_change, head.has_next, head.chosen_type,
                     head.abbr_offset, head.dst_flag, head.zone_offset};

`ifndef SYNTHESIS
  // skid is only ever filled behind a waiting head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry held without a head entry");

  // a finished file always leaves a result on the output
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("last byte taken but no result shown");

  // status code stays in its defined range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= ST_RANGE))
    else $error("undefined status code");

  // bad magic, truncated and default utc carry an all-zero payload
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK && m_tuser != ST_RANGE) |-> (m_tdata == '0))
    else $error("nonzero payload on an error result");
`endif

endmodule
